[rtl/glyph_outline_compositor_assert.svh]
// Assertion macros used by the glyph outline compositor RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef GLYPH_OUTLINE_COMPOSITOR_ASSERT_SVH
`define GLYPH_OUTLINE_COMPOSITOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GOCMP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gocmp: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GOCMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gocmp: next-cycle check failed");

`endif

[rtl/gocmp_pkg.sv]
// Shared types, constants and helpers for the glyph outline compositor.
// No dependencies; every RTL module imports this package.
package gocmp_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DIM_W  = 7;
  localparam int POS_W  = 8;
  localparam int CPOS_W = POS_W + 1;
  localparam int PIX_W  = 8;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_OUTLINE_MODE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GLYPH_WIDTH    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GLYPH_HEIGHT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BODY_THRESHOLD = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BODY_SHADE     = 3'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd128;
  localparam logic [PIX_W-1:0] SHADE_RESET     = 8'd236;
  localparam logic [PIX_W-1:0] WHITE_LEVEL     = 8'd255;
  localparam logic [PIX_W-1:0] OPAQUE          = 8'd255;

  typedef struct packed {
    logic                    op;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [PIX_W-1:0]        coverage;
  } in_item_t;

  typedef struct packed {
    logic             paint;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } out_item_t;

  // Configuration as seen by the datapath, dimensions already saturated.
  typedef struct packed {
    logic             outline_mode;
    logic [DIM_W-1:0] eff_width;
    logic [DIM_W-1:0] eff_height;
    logic [PIX_W-1:0] body_threshold;
    logic [PIX_W-1:0] body_shade;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
  } store_rd_t;

  // True when a sign-extended position lies in 0 .. lim-1.
  function automatic logic pos_inside(logic signed [CPOS_W-1:0] p, logic [DIM_W-1:0] lim);
    logic signed [CPOS_W-1:0] lim_s;
    lim_s = $signed({{(CPOS_W-DIM_W){1'b0}}, lim});
    return (p >= 0) && (p < lim_s);
  endfunction

endpackage

[rtl/gocmp_cfg_regs.sv]
// APB-style configuration registers of the glyph outline compositor.
// Depends on gocmp_pkg; saturates the glyph dimensions for the datapath.
module gocmp_cfg_regs
  import gocmp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic             outline_mode_r;
  logic [DIM_W-1:0] glyph_width_r;
  logic [DIM_W-1:0] glyph_height_r;
  logic [PIX_W-1:0] body_threshold_r;
  logic [PIX_W-1:0] body_shade_r;

  logic                 wr_fire;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outline_mode_r   <= 1'b0;
      glyph_width_r    <= '0;
      glyph_height_r   <= '0;
      body_threshold_r <= THRESHOLD_RESET;
      body_shade_r     <= SHADE_RESET;
    end else if (wr_fire) begin
      case (reg_idx)
        REG_OUTLINE_MODE:   outline_mode_r   <= pwdata[0];
        REG_GLYPH_WIDTH:    glyph_width_r    <= pwdata[DIM_W-1:0];
        REG_GLYPH_HEIGHT:   glyph_height_r   <= pwdata[DIM_W-1:0];
        REG_BODY_THRESHOLD: body_threshold_r <= pwdata[PIX_W-1:0];
        REG_BODY_SHADE:     body_shade_r     <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OUTLINE_MODE:   prdata = CFG_DATA_W'(outline_mode_r);
      REG_GLYPH_WIDTH:    prdata = CFG_DATA_W'(glyph_width_r);
      REG_GLYPH_HEIGHT:   prdata = CFG_DATA_W'(glyph_height_r);
      REG_BODY_THRESHOLD: prdata = CFG_DATA_W'(body_threshold_r);
      REG_BODY_SHADE:     prdata = CFG_DATA_W'(body_shade_r);
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.outline_mode   = outline_mode_r;
    cfg_o.eff_width      = (int'(glyph_width_r) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : glyph_width_r;
    cfg_o.eff_height     = (int'(glyph_height_r) > MAX_HEIGHT) ?
                           DIM_W'(MAX_HEIGHT) : glyph_height_r;
    cfg_o.body_threshold = body_threshold_r;
    cfg_o.body_shade     = body_shade_r;
  end

endmodule

[rtl/gocmp_coverage_store.sv]
// Coverage bitmap memory: one glyph row per word, byte-wide write port.
// Depends on gocmp_pkg; a row read returns registered data in the following cycle.
module gocmp_coverage_store
  import gocmp_pkg::*;
(
  input  logic             clk,
  input  store_wr_t        wr_i,
  input  store_rd_t        rd_i,
  input  logic [COL_W-1:0] tap_col_i  [3],
  output logic [PIX_W-1:0] tap_data_o [3]
);

  logic [MAX_WIDTH*PIX_W-1:0] mem_r [MAX_HEIGHT];
  logic [MAX_WIDTH*PIX_W-1:0] row_q_r;

  always_ff @(posedge clk) begin
    if (wr_i.en) begin
      mem_r[wr_i.row][wr_i.col*PIX_W +: PIX_W] <= wr_i.data;
    end
    if (rd_i.en) begin
      row_q_r <= mem_r[rd_i.row];
    end
  end

  // Three neighboring columns picked out of the registered row.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tap_data_o[k] = row_q_r[tap_col_i[k]*PIX_W +: PIX_W];
    end
  end

endmodule

[rtl/gocmp_query_ctrl.sv]
// Item sequencer: stores writes, walks the three rows around a query and
// builds the painted color. Depends on gocmp_pkg and the assertion macros.
`include "glyph_outline_compositor_assert.svh"

module gocmp_query_ctrl
  import gocmp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg_i,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  output store_wr_t        wr_o,
  output store_rd_t        rd_o,
  output logic [COL_W-1:0] tap_col_o  [3],
  input  logic [PIX_W-1:0] tap_data_i [3]
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROW  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [1:0]              ph_r, ph_nxt;
  logic signed [POS_W-1:0] qx_r, qy_r;
  logic                    any_r, any_nxt;
  logic                    ctr_body_r, ctr_body_nxt;
  logic [PIX_W-1:0]        ctr_cov_r, ctr_cov_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  logic                     in_fire, load;
  logic signed [CPOS_W-1:0] in_x9, in_y9, qx9, qy9, rd_y, ev_y;
  logic signed [CPOS_W-1:0] tap_x [3];
  logic [1:0]               ev_row;
  logic                     ev_active, row_ok, row_body;
  logic [2:0]               col_ok, tap_body;
  logic                     any_all;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load      = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  assign in_x9 = CPOS_W'(in_data.pos_x);
  assign in_y9 = CPOS_W'(in_data.pos_y);
  assign qx9   = CPOS_W'(qx_r);
  assign qy9   = CPOS_W'(qy_r);

  // A write lands in the memory at the edge that accepts it.
  always_comb begin
    wr_o.en   = in_fire && (in_data.op == OP_WRITE) &&
                pos_inside(in_x9, cfg_i.eff_width) && pos_inside(in_y9, cfg_i.eff_height);
    wr_o.row  = in_data.pos_y[ROW_W-1:0];
    wr_o.col  = in_data.pos_x[COL_W-1:0];
    wr_o.data = in_data.coverage;
  end

  // Row y-1, y, y+1 are read in phases 0, 1, 2; each is evaluated next cycle.
  assign rd_y     = qy9 + CPOS_W'(ph_r) - CPOS_W'(1);
  assign rd_o.en  = (state_r == ST_ROW);
  assign rd_o.row = rd_y[ROW_W-1:0];

  assign ev_row    = (state_r == ST_FIN) ? 2'd2 : ph_r - 2'd1;
  assign ev_active = ((state_r == ST_ROW) && (ph_r != 2'd0)) || (state_r == ST_FIN);
  assign ev_y      = qy9 + CPOS_W'(ev_row) - CPOS_W'(1);
  assign row_ok    = pos_inside(ev_y, cfg_i.eff_height);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tap_x[k]     = qx9 + CPOS_W'(k) - CPOS_W'(1);
      tap_col_o[k] = tap_x[k][COL_W-1:0];
      col_ok[k]    = pos_inside(tap_x[k], cfg_i.eff_width);
      tap_body[k]  = row_ok && col_ok[k] && (tap_data_i[k] >= cfg_i.body_threshold);
    end
  end

  assign row_body = |tap_body;
  assign any_all  = any_r || row_body;

  always_comb begin
    state_nxt    = state_r;
    ph_nxt       = ph_r;
    any_nxt      = any_r;
    ctr_body_nxt = ctr_body_r;
    ctr_cov_nxt  = ctr_cov_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_data.op == OP_QUERY)) begin
          state_nxt = ST_ROW;
          ph_nxt    = 2'd0;
          any_nxt   = 1'b0;
        end
      end
      ST_ROW: begin
        if (ev_active) begin
          any_nxt = any_r || row_body;
          if (ev_row == 2'd1) begin
            ctr_body_nxt = tap_body[1];
            ctr_cov_nxt  = (row_ok && col_ok[1]) ? tap_data_i[1] : '0;
          end
        end
        if (ph_r == 2'd2) begin
          state_nxt = ST_FIN;
        end else begin
          ph_nxt = ph_r + 2'd1;
        end
      end
      ST_FIN: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_data_nxt = '0;
    if (!cfg_i.outline_mode) begin
      if (ctr_cov_r != '0) begin
        out_data_nxt.paint = 1'b1;
        out_data_nxt.red   = WHITE_LEVEL;
        out_data_nxt.green = WHITE_LEVEL;
        out_data_nxt.blue  = WHITE_LEVEL;
        out_data_nxt.alpha = ctr_cov_r;
      end
    end else if (ctr_body_r) begin
      out_data_nxt.paint = 1'b1;
      out_data_nxt.red   = cfg_i.body_shade;
      out_data_nxt.green = cfg_i.body_shade;
      out_data_nxt.blue  = cfg_i.body_shade;
      out_data_nxt.alpha = OPAQUE;
    end else if (any_all) begin
      out_data_nxt.paint = 1'b1;
      out_data_nxt.alpha = OPAQUE;
    end
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    any_r      <= any_nxt;
    ctr_body_r <= ctr_body_nxt;
    ctr_cov_r  <= ctr_cov_nxt;
    if (in_fire) begin
      qx_r <= in_data.pos_x;
      qy_r <= in_data.pos_y;
    end
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  `GOCMP_ASSERT_NEXT(a_query_starts, in_fire && (in_data.op == OP_QUERY), (state_r == ST_ROW) && (ph_r == 2'd0))
  `GOCMP_ASSERT_NEXT(a_rows_then_fin, (state_r == ST_ROW) && (ph_r == 2'd2), state_r == ST_FIN)
  `GOCMP_ASSERT_SAME(a_write_when_idle, wr_o.en, state_r == ST_IDLE)
  `GOCMP_ASSERT_NEXT(a_load_shows, load, out_valid_r)
  `GOCMP_ASSERT_SAME(a_unpainted_zero, out_valid_r && !out_data_r.paint, (out_data_r.alpha == '0) && (out_data_r.red == '0) && (out_data_r.blue == '0))

endmodule

[rtl/glyph_outline_compositor.sv]
// Top level of the glyph outline compositor.
// Depends on gocmp_pkg, gocmp_cfg_regs, gocmp_coverage_store, gocmp_query_ctrl.
//
//   Port group   Direction   Handshake                 Moves
//   in_*         input       in_valid / in_ready       one write or query item
//   out_*        output      out_valid / out_ready     one painted color item
//   APB          input       psel / penable, pready=1  register writes and reads
//
// A write item is stored at the edge that accepts it.
// A query item holds off further items until it is through: three row reads
// of the row memory plus a final evaluation state, ST_FIN.
// Reset clears control state and the configuration registers; bitmap contents stay undefined.
// A query result waits in the output register while out_ready is low; the
// next item is accepted meanwhile, and a later query holds in its last cycle.
module glyph_outline_compositor
  import gocmp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t             cfg;
  store_wr_t        st_wr;
  store_rd_t        st_rd;
  logic [COL_W-1:0] tap_col  [3];
  logic [PIX_W-1:0] tap_data [3];

  gocmp_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gocmp_coverage_store u_store (
    .clk        (clk),
    .wr_i       (st_wr),
    .rd_i       (st_rd),
    .tap_col_i  (tap_col),
    .tap_data_o (tap_data)
  );

  gocmp_query_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .wr_o       (st_wr),
    .rd_o       (st_rd),
    .tap_col_o  (tap_col),
    .tap_data_i (tap_data)
  );

endmodule

[tb/sv/glyph_outline_compositor_tb.sv]
// Self-checking testbench for the glyph outline compositor.
// Depends on gocmp_pkg and the glyph_outline_compositor RTL; it predicts every
// painted color from its own copy of the bitmap and the register settings.
`timescale 1ns / 100ps

module glyph_outline_compositor_tb
  import gocmp_pkg::*;
();

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  glyph_outline_compositor uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Mirror of the register file and of the coverage bitmap.
  bit             mode_outline;
  bit [DIM_W-1:0] width_reg;
  bit [DIM_W-1:0] height_reg;
  bit [PIX_W-1:0] threshold_reg;
  bit [PIX_W-1:0] shade_reg;
  bit [PIX_W-1:0] glyph_cov [0:MAX_WIDTH*MAX_HEIGHT-1];

  out_item_t expected_paints[$];

  int in_gap_max;
  int out_gap_max;
  int stall_request;
  int fail_count;
  int n_writes;
  int n_queries;
  int n_results;
  int n_reg_writes;

  always #2 clk = ~clk;

  function automatic int eff_dim(bit [DIM_W-1:0] d, int lim);
    return (d > lim) ? lim : int'(d);
  endfunction

  function automatic bit in_glyph(int x, int y);
    return x >= 0 && y >= 0 && x < eff_dim(width_reg, MAX_WIDTH) &&
           y < eff_dim(height_reg, MAX_HEIGHT);
  endfunction

  function automatic bit is_body(int x, int y);
    return in_glyph(x, y) && glyph_cov[y*MAX_WIDTH + x] >= threshold_reg;
  endfunction

  function automatic out_item_t paint_at(int x, int y);
    out_item_t res;
    bit touches;
    res = '0;
    touches = 1'b0;
    if (!mode_outline) begin
      if (in_glyph(x, y) && glyph_cov[y*MAX_WIDTH + x] != 0) begin
        res.paint = 1'b1;
        res.red   = WHITE_LEVEL;
        res.green = WHITE_LEVEL;
        res.blue  = WHITE_LEVEL;
        res.alpha = glyph_cov[y*MAX_WIDTH + x];
      end
    end else if (is_body(x, y)) begin
      res.paint = 1'b1;
      res.red   = shade_reg;
      res.green = shade_reg;
      res.blue  = shade_reg;
      res.alpha = OPAQUE;
    end else begin
      for (int dy = -1; dy <= 1; dy++)
        for (int dx = -1; dx <= 1; dx++)
          if (is_body(x + dx, y + dy)) touches = 1'b1;
      if (touches) begin
        res.paint = 1'b1;
        res.alpha = OPAQUE;
      end
    end
    return res;
  endfunction

  // Mostly blank or solid pixels with some within one of the threshold, so that
  // outline mode sees real shapes with edges.
  function automatic int draw_coverage();
    int r;
    int c;
    r = $urandom_range(0, 9);
    if (r < 4) return 0;
    if (r < 6) return 255;
    if (r < 8) begin
      c = int'(threshold_reg) + $urandom_range(0, 2) - 1;
      return (c < 0) ? 0 : (c > 255) ? 255 : c;
    end
    return $urandom_range(0, 255);
  endfunction

  function automatic int pick_pos(int dim);
    int v;
    if ($urandom_range(0, 19) == 0) begin
      v = $urandom_range(0, 255);
      return v - 128;
    end
    v = $urandom_range(0, dim + 1);
    return v - 1;
  endfunction

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_OUTLINE_MODE:   mode_outline  = value[0];
      REG_GLYPH_WIDTH:    width_reg     = value[DIM_W-1:0];
      REG_GLYPH_HEIGHT:   height_reg    = value[DIM_W-1:0];
      REG_BODY_THRESHOLD: threshold_reg = value[PIX_W-1:0];
      REG_BODY_SHADE:     shade_reg     = value[PIX_W-1:0];
      default: ;
    endcase
    n_reg_writes++;
  endtask

  // Drops valid, waits for every outstanding query, then lets the pipeline
  // settle so that registers may be rewritten safely.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_paints.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_item(in_item_t item);
    int gap;
    int x;
    int y;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    x = int'($signed(item.pos_x));
    y = int'($signed(item.pos_y));
    if (item.op == OP_WRITE) begin
      if (in_glyph(x, y)) glyph_cov[y*MAX_WIDTH + x] = item.coverage;
      n_writes++;
    end else begin
      expected_paints.insert(expected_paints.size(), paint_at(x, y));
      n_queries++;
    end
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_write(int x, int y, int cov);
    in_item_t item;
    item.op       = OP_WRITE;
    item.pos_x    = x[POS_W-1:0];
    item.pos_y    = y[POS_W-1:0];
    item.coverage = cov[PIX_W-1:0];
    send_item(item);
  endtask

  task automatic send_query(int x, int y);
    in_item_t item;
    item.op       = OP_QUERY;
    item.pos_x    = x[POS_W-1:0];
    item.pos_y    = y[POS_W-1:0];
    item.coverage = $urandom_range(0, 255);
    send_item(item);
  endtask

  task automatic fill_glyph();
    for (int y = 0; y < eff_dim(height_reg, MAX_HEIGHT); y++)
      for (int x = 0; x < eff_dim(width_reg, MAX_WIDTH); x++)
        send_write(x, y, draw_coverage());
  endtask

  task automatic set_glyph(int mode, int w, int h, int thr, int shade);
    wait_for_results();
    write_reg(REG_OUTLINE_MODE, mode);
    write_reg(REG_GLYPH_WIDTH, w);
    write_reg(REG_GLYPH_HEIGHT, h);
    write_reg(REG_BODY_THRESHOLD, thr);
    write_reg(REG_BODY_SHADE, shade);
  endtask

  task automatic random_items(int count);
    int w;
    int h;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        if (w > 0 && h > 0 && $urandom_range(0, 6) != 0)
          send_write($urandom_range(0, w - 1), $urandom_range(0, h - 1), draw_coverage());
        else
          send_write(pick_pos(w), pick_pos(h), $urandom_range(0, 255));
      end else begin
        send_query(pick_pos(w), pick_pos(h));
      end
    end
  endtask

  // Straight out of reset the glyph has no size, so nothing paints and
  // writes are dropped.
  task automatic test_reset_defaults();
    in_gap_max  = 10;
    out_gap_max = 10;
    send_write(0, 0, 255);
    send_query(0, 0);
    send_query(-1, -1);
    send_query(64, 64);
    send_query(-128, 127);
  endtask

  task automatic test_directed();
    set_glyph(0, 3, 2, THRESHOLD_RESET, SHADE_RESET);
    send_write(0, 0, 0);
    send_write(1, 0, 127);
    send_write(2, 0, 128);
    send_write(0, 1, 1);
    send_write(1, 1, 254);
    send_write(2, 1, 255);
    // Writes that fall outside the glyph must leave the bitmap untouched.
    send_write(3, 0, 200);
    send_write(0, 2, 200);
    send_write(-1, -1, 200);
    send_query(0, 0);
    send_query(1, 0);
    send_query(0, 1);
    send_query(2, 1);
    send_query(-1, -1);
    send_query(3, 2);
    wait_for_results();
    write_reg(REG_OUTLINE_MODE, 1);
    send_query(0, 0);
    send_query(1, 0);
    send_query(2, 0);
    send_query(0, 1);
    send_query(3, 0);
    send_query(-1, 1);
    send_query(3, 2);
    send_query(-128, 127);
  endtask

  task automatic test_random_glyphs(int phases);
    int mode;
    int w;
    int h;
    int thr;
    int shade;
    int r;
    for (int p = 0; p < phases; p++) begin
      mode  = $urandom_range(0, 1);
      thr   = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 255);
      shade = $urandom_range(0, 4) == 0 ? 255 : $urandom_range(0, 255);
      r = $urandom_range(0, 9);
      w = (r == 0) ? 0 : (r == 1) ? $urandom_range(64, 127) : $urandom_range(1, 12);
      r = $urandom_range(0, 9);
      h = (r == 0) ? 0 : (r == 1) ? $urandom_range(64, 127) : $urandom_range(1, 12);
      if (eff_dim(DIM_W'(w), MAX_WIDTH) * eff_dim(DIM_W'(h), MAX_HEIGHT) > 400)
        h = $urandom_range(1, 4);
      // Pin outline mode with threshold and shade extremes in the first two phases, smooth mode in the third.
      if (p == 0) begin
        mode = 1; thr = 0; shade = 255;
      end else if (p == 1) begin
        mode = 1; thr = 255; shade = 0;
      end else if (p == 2) begin
        mode = 0;
      end
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 10;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      set_glyph(mode, w, h, thr, shade);
      fill_glyph();
      random_items(100);
    end
  endtask

  // Dimensions above the bitmap size saturate to 64 in each direction.
  task automatic test_oversized();
    in_gap_max  = 10;
    out_gap_max = 10;
    set_glyph(1, 127, 2, 100, 180);
    fill_glyph();
    send_query(63, 0);
    send_query(64, 1);
    send_query(65, 0);
    random_items(40);
    set_glyph(1, 3, 100, 100, 180);
    fill_glyph();
    send_query(1, 63);
    send_query(2, 64);
    send_query(0, 65);
    random_items(40);
  endtask

  // The receiver stops for a long stretch while queries keep coming, so the
  // output register fills and the input has to stall.
  task automatic test_output_stall();
    set_glyph(1, 8, 6, 128, 236);
    fill_glyph();
    wait_for_results();
    in_gap_max    = 0;
    stall_request = 300;
    for (int i = 0; i < 30; i++) send_query(pick_pos(8), pick_pos(6));
    in_gap_max = 10;
    random_items(30);
  endtask

  // Receiver and result checker.
  initial begin
    out_item_t want;
    int pause;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (stall_request > 0) begin
        pause = stall_request;
        stall_request = 0;
      end else begin
        pause = $urandom_range(0, out_gap_max);
      end
      if (pause > 0) begin
        out_ready <= 1'b0;
        for (int c = 0; c < pause; c++) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      n_results++;
      if (expected_paints.size() == 0) begin
        if (fail_count < 10)
          $display("ERROR: result with no query pending: paint=%0d rgba=%0d/%0d/%0d/%0d",
                   out_data.paint, out_data.red, out_data.green, out_data.blue,
                   out_data.alpha);
        fail_count++;
      end else begin
        want = expected_paints.pop_front();
        if (out_data.paint !== want.paint || out_data.red !== want.red ||
            out_data.green !== want.green || out_data.blue !== want.blue ||
            out_data.alpha !== want.alpha) begin
          if (fail_count < 10)
            $display("ERROR: result %0d expected paint=%0d rgba=%0d/%0d/%0d/%0d, got paint=%0d rgba=%0d/%0d/%0d/%0d",
                     n_results, want.paint, want.red, want.green, want.blue, want.alpha,
                     out_data.paint, out_data.red, out_data.green, out_data.blue,
                     out_data.alpha);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("ERROR: run timed out with %0d results outstanding", expected_paints.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    mode_outline  = 1'b0;
    width_reg     = '0;
    height_reg    = '0;
    threshold_reg = THRESHOLD_RESET;
    shade_reg     = SHADE_RESET;
    in_gap_max    = 10;
    out_gap_max   = 10;
    stall_request = 0;
    fail_count    = 0;
    n_writes      = 0;
    n_queries     = 0;
    n_results     = 0;
    n_reg_writes  = 0;
    foreach (glyph_cov[i]) glyph_cov[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed();
    test_random_glyphs(8);
    test_oversized();
    test_output_stall();
    wait_for_results();
    repeat (20) @(posedge clk);

    $display("Sent %0d writes and %0d queries, checked %0d results, %0d register writes.",
             n_writes, n_queries, n_results, n_reg_writes);
    $display("Covered smooth and outline modes, saturated sizes and a long output stall.");
    if (fail_count == 0 && expected_paints.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/gocmp_pkg.sv
rtl/gocmp_cfg_regs.sv
rtl/gocmp_coverage_store.sv
rtl/gocmp_query_ctrl.sv
rtl/glyph_outline_compositor.sv
tb/sv/glyph_outline_compositor_tb.sv
